@@ design/csbs_pkg.sv @@
// Shared types, constants and helpers for the chunk stream block splitter.
package csbs_pkg;

  // Default sizing of the splitter.
  localparam int HEADER_BYTES_DEFAULT     = 3;
  localparam int MAX_BUFFER_BYTES_DEFAULT = 65535;
  localparam int QUEUE_DEPTH_DEFAULT      = 4;

  // Offsets and lengths within one buffer.
  localparam int OFS_W = 16;
  localparam logic [OFS_W-1:0] MAX_BLOCK_RESET = 16'd64;

  // Buffer status reported with every result.
  typedef enum logic [1:0] {
    STATUS_CONTINUES = 2'd0,
    STATUS_OK        = 2'd1,
    STATUS_CORRUPT   = 2'd2
  } status_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [OFS_W-1:0] block_start;
    logic [OFS_W-1:0] block_length;
    logic             has_block;
    status_t          status;
  } result_t;

  // Everything one input byte causes: one result, or two when a split and
  // the end of the buffer fall on the same byte.
  typedef struct packed {
    result_t first;
    logic    two;
    result_t second;
  } rec_t;

  // Builds a result; offset and length read as zero when no block is given.
  function automatic result_t mk_result(input logic [OFS_W-1:0] start,
                                        input logic [OFS_W-1:0] len,
                                        input logic valid,
                                        input status_t status);
    result_t r;
    r.block_start  = valid ? start : '0;
    r.block_length = valid ? len : '0;
    r.has_block    = valid;
    r.status       = status;
    return r;
  endfunction

endpackage

@@ design/csbs_byte_if.sv @@
// Byte stream channel carrying the chunked buffer.
interface csbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/csbs_result_if.sv @@
// Result channel carrying emitted blocks and buffer status.
interface csbs_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_start;
  logic [15:0] block_length;
  logic        has_block;
  logic [1:0]  buffer_status;
  logic        last_result;

  modport source (output valid, output block_start, output block_length,
                  output has_block, output buffer_status, output last_result,
                  input ready);
  modport sink (input valid, input block_start, input block_length,
                input has_block, input buffer_status, input last_result,
                output ready);
endinterface

@@ design/csbs_cfg_if.sv @@
// Configuration write channel for the largest block size.
interface csbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_block_size;

  modport source (output valid, output max_block_size, input ready);
  modport sink (input valid, input max_block_size, output ready);
endinterface

@@ design/csbs_front.sv @@
// Front end: parses chunk headers byte by byte and decides the splits.
module csbs_front #(
  parameter int HEADER_BYTES     = csbs_pkg::HEADER_BYTES_DEFAULT,
  parameter int MAX_BUFFER_BYTES = csbs_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  csbs_byte_if.sink        stream,
  csbs_cfg_if.sink         cfg,
  input  logic             q_full,
  output logic             push,
  output csbs_pkg::rec_t   push_rec
);
  import csbs_pkg::*;

  localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 2);
  localparam int HI_W  = $clog2(HEADER_BYTES);
  localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_BUFFER_BYTES);
  localparam logic [POS_W-1:0] OVER_POS = POS_W'(MAX_BUFFER_BYTES + 1);
  localparam logic [HI_W-1:0]  HI_LAST  = HI_W'(HEADER_BYTES - 1);

  logic [OFS_W-1:0] max_block_size;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [OFS_W-1:0] block_begin, block_begin_next;
  logic [OFS_W-1:0] last_chunk_end, last_chunk_end_next;
  logic [HI_W-1:0]  header_index, header_index_next;
  logic [7:0]       payload_left, payload_left_next;
  logic             header_nonzero, header_nonzero_next;

  logic             accept;
  logic             has_rec;
  logic             chunk_done;
  logic             split;
  logic [OFS_W-1:0] end_ofs;
  logic [OFS_W-1:0] pending_len;
  rec_t             rec;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !q_full;
  assign accept       = stream.valid && stream.ready;
  assign push         = accept && has_rec;
  assign push_rec     = rec;

  // Offset just past the current byte, and whether a chunk end here splits.
  assign end_ofs     = OFS_W'(byte_position) + 16'd1;
  assign split       = (end_ofs - block_begin) > max_block_size;
  assign pending_len = last_chunk_end - block_begin;

  // Next state and the result record for the byte on the channel.
  always_comb begin
    byte_position_next  = byte_position;
    block_begin_next    = block_begin;
    last_chunk_end_next = last_chunk_end;
    header_index_next   = header_index;
    payload_left_next   = payload_left;
    header_nonzero_next = header_nonzero;
    chunk_done          = 1'b0;
    has_rec             = 1'b0;
    rec                 = '0;

    if (byte_position >= MAX_POS) begin
      // Buffer grew too long: swallow bytes until the last one.
      byte_position_next = OVER_POS;
      if (stream.last_byte) begin
        rec.first = mk_result('0, '0, 1'b0, STATUS_CORRUPT);
        has_rec   = 1'b1;
      end
    end else begin
      byte_position_next = byte_position + POS_W'(1);
      if (header_index == '0 && payload_left == '0) begin
        payload_left_next   = stream.data_byte;
        header_nonzero_next = (stream.data_byte != 8'd0);
        header_index_next   = HI_W'(1);
      end else if (header_index != '0) begin
        header_nonzero_next = header_nonzero || (stream.data_byte != 8'd0);
        if (header_index == HI_LAST) begin
          header_index_next = '0;
          chunk_done        = (payload_left == '0);
        end else begin
          header_index_next = header_index + HI_W'(1);
        end
      end else begin
        payload_left_next = payload_left - 8'd1;
        chunk_done        = (payload_left == 8'd1);
      end

      if (chunk_done) begin
        if (split) begin
          rec.first        = mk_result(block_begin, pending_len, 1'b1, STATUS_CONTINUES);
          block_begin_next = last_chunk_end;
        end
        if (stream.last_byte) begin
          if (split) begin
            rec.two    = 1'b1;
            rec.second = mk_result(last_chunk_end, end_ofs - last_chunk_end,
                                   1'b1, STATUS_OK);
          end else begin
            rec.first = mk_result(block_begin, end_ofs - block_begin, 1'b1, STATUS_OK);
          end
        end else begin
          last_chunk_end_next = end_ofs;
        end
        has_rec = split || stream.last_byte;
      end else if (stream.last_byte) begin
        // A trailing header of zeros is padding; anything else is corrupt.
        if (header_index_next != '0 && !header_nonzero_next) begin
          rec.first = mk_result(block_begin, pending_len, pending_len != '0, STATUS_OK);
        end else begin
          rec.first = mk_result('0, '0, 1'b0, STATUS_CORRUPT);
        end
        has_rec = 1'b1;
      end
    end

    // Every buffer end returns the parser to its start.
    if (stream.last_byte) begin
      byte_position_next  = '0;
      block_begin_next    = '0;
      last_chunk_end_next = '0;
      header_index_next   = '0;
      payload_left_next   = '0;
      header_nonzero_next = 1'b0;
    end
  end

  // Parser state advances on each byte transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      block_begin    <= '0;
      last_chunk_end <= '0;
      header_index   <= '0;
      payload_left   <= '0;
      header_nonzero <= 1'b0;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      block_begin    <= block_begin_next;
      last_chunk_end <= last_chunk_end_next;
      header_index   <= header_index_next;
      payload_left   <= payload_left_next;
      header_nonzero <= header_nonzero_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_size <= MAX_BLOCK_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_block_size <= cfg.max_block_size;
    end
  end

  // The current block never starts past the latest chunk end.
  a_begin_order: assert property (@(posedge clk) disable iff (rst)
    block_begin <= last_chunk_end)
    else $error("block start passed the latest chunk end");

  // A buffer end always leaves the parser at offset zero.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && stream.last_byte |=> byte_position == '0 && header_index == '0)
    else $error("parser not cleared after the last byte");

endmodule

@@ design/csbs_queue.sv @@
// Short queue of result records between the front and back ends.
module csbs_queue #(
  parameter int DEPTH = csbs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csbs_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output csbs_pkg::rec_t head_rec,
  output logic           nonempty
);
  import csbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rec_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW + 1)'(DEPTH));
  assign nonempty = (count != '0);
  assign head_rec = entries[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  // Neither side may overrun or underrun the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push |-> !full) and (pop |-> nonempty))
    else $error("queue overrun or underrun");

endmodule

@@ design/csbs_back.sv @@
// Back end: serializes result records onto the output channel.
module csbs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  csbs_pkg::rec_t q_rec,
  output logic           pop,
  csbs_result_if.source  blocks
);
  import csbs_pkg::*;

  logic    out_valid;
  result_t out_res;
  logic    out_last;
  logic    sel;
  logic    load;

  assign load = q_valid && (!out_valid || blocks.ready);
  assign pop  = load && (sel || !q_rec.two);

  assign blocks.valid         = out_valid;
  assign blocks.block_start   = out_res.block_start;
  assign blocks.block_length  = out_res.block_length;
  assign blocks.has_block     = out_res.has_block;
  assign blocks.buffer_status = out_res.status;
  assign blocks.last_result   = out_last;

  // Output register control and slot select.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= !sel && q_rec.two;
      end else if (blocks.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= sel ? q_rec.second : q_rec.first;
      out_last <= sel || !q_rec.two;
    end
  end

  // The second slot is only ever taken from a record still at the head.
  a_sel_head: assert property (@(posedge clk) disable iff (rst)
    sel |-> q_valid)
    else $error("second result pending with an empty queue");

  // Without a block, the offset and length read as zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.has_block |->
      out_res.block_start == '0 && out_res.block_length == '0)
    else $error("offset or length set on a result without a block");

endmodule

@@ design/chunk_stream_block_splitter.sv @@
// Top level of the chunk stream block splitter.
//
// The stream channel takes one byte of a chunked buffer per transaction,
// with last_byte marking the final byte. Each chunk is a header (size byte
// and code) followed by size payload bytes. The blocks channel gives the
// emitted blocks: one result for a split, one at the buffer end, or two when
// both fall on the same byte; last_result marks the final result of a byte.
// The cfg channel writes max_block_size; it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce it.
// Throughput: one byte per cycle on the stream channel while the queue has
// room, and one result per cycle on the blocks channel while the receiver
// is ready. A result passes through the queue and the output register.
// A queue of QUEUE_DEPTH records sits between parser and output register,
// so bytes keep flowing while the receiver stalls; once it fills, stream
// ready drops until the receiver takes results again.
// Reset clears the parser, the queue and the output, and sets
// max_block_size to 64.
module chunk_stream_block_splitter #(
  parameter int HEADER_BYTES     = csbs_pkg::HEADER_BYTES_DEFAULT,
  parameter int MAX_BUFFER_BYTES = csbs_pkg::MAX_BUFFER_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH      = csbs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  csbs_byte_if.sink     stream,
  csbs_cfg_if.sink      cfg,
  csbs_result_if.source blocks
);
  import csbs_pkg::*;

  logic q_full;
  logic push;
  rec_t push_rec;
  logic pop;
  rec_t head_rec;
  logic q_valid;

  csbs_front #(
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .cfg     (cfg),
    .q_full  (q_full),
    .push    (push),
    .push_rec(push_rec)
  );

  csbs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .full    (q_full),
    .pop     (pop),
    .head_rec(head_rec),
    .nonempty(q_valid)
  );

  csbs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_rec  (head_rec),
    .pop    (pop),
    .blocks (blocks)
  );

endmodule

@@ test/csbs_tb_pkg.sv @@
// Scoreboard for the chunk stream block splitter bench: expected-block model and result checker.
`timescale 1ns / 100ps
package csbs_tb_pkg;
  import csbs_pkg::*;

  localparam int CHUNK_HEADER = HEADER_BYTES_DEFAULT;
  localparam int BUFFER_LIMIT = MAX_BUFFER_BYTES_DEFAULT;

  // One expected transaction on the blocks channel.
  typedef struct packed {
    logic [OFS_W-1:0] block_start;
    logic [OFS_W-1:0] block_length;
    logic             has_block;
    status_t          status;
    logic             last_result;
  } block_outcome_t;

  class block_scoreboard;
    logic [OFS_W-1:0] max_block;
    logic [16:0]      byte_pos;
    logic [OFS_W-1:0] block_begin;
    logic [OFS_W-1:0] last_chunk_end;
    logic [1:0]       header_idx;
    logic [7:0]       payload_left;
    logic             header_nonzero;
    block_outcome_t   expected_blocks[$];
    int unsigned      mismatches;

    function new();
      max_block  = MAX_BLOCK_RESET;
      mismatches = 0;
      clear_buffer();
    endfunction

    // Parser state goes back to the start of a buffer; the size limit stays.
    function void clear_buffer();
      byte_pos       = '0;
      block_begin    = '0;
      last_chunk_end = '0;
      header_idx     = '0;
      payload_left   = '0;
      header_nonzero = 1'b0;
    endfunction

    function void set_max_block(logic [OFS_W-1:0] value);
      max_block = value;
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    // Offset and length read as zero whenever no block is reported.
    function block_outcome_t outcome(logic [OFS_W-1:0] start, logic [OFS_W-1:0] len,
                                     logic valid, status_t status);
      block_outcome_t r;
      r.block_start  = valid ? start : '0;
      r.block_length = valid ? len : '0;
      r.has_block    = valid;
      r.status       = status;
      r.last_result  = 1'b0;
      return r;
    endfunction

    // Advances the parser by one accepted byte and queues what it must emit.
    function void note_byte(logic [7:0] data, logic last);
      block_outcome_t outs[$];
      int unsigned    stop;
      logic [OFS_W-1:0] len;
      bit             chunk_done;
      chunk_done = 1'b0;
      if (byte_pos >= BUFFER_LIMIT) begin
        // The buffer grew too long: bytes are swallowed until its last one.
        byte_pos = 17'(BUFFER_LIMIT + 1);
        if (last) begin
          outs.insert(outs.size(), outcome('0, '0, 1'b0, STATUS_CORRUPT));
          clear_buffer();
        end
      end else begin
        stop     = byte_pos + 1;
        byte_pos = 17'(stop);

        // Walk the chunk structure: size byte, code bytes, then the payload.
        if (header_idx == 0 && payload_left == 0) begin
          payload_left   = data;
          header_nonzero = (data != 0);
          header_idx     = 2'd1;
        end else if (header_idx != 0) begin
          if (data != 0) begin
            header_nonzero = 1'b1;
          end
          if (header_idx + 1 >= CHUNK_HEADER) begin
            header_idx = '0;
            chunk_done = (payload_left == 0);
          end else begin
            header_idx = header_idx + 2'd1;
          end
        end else begin
          payload_left = payload_left - 8'd1;
          chunk_done   = (payload_left == 0);
        end

        if (chunk_done) begin
          // Split at the previous chunk end when the span got too wide.
          if (stop - block_begin > max_block) begin
            outs.insert(outs.size(), outcome(block_begin, last_chunk_end - block_begin,
                                             1'b1, STATUS_CONTINUES));
            block_begin = last_chunk_end;
          end
          if (last) begin
            outs.insert(outs.size(), outcome(block_begin, 16'(stop - block_begin), 1'b1,
                                             STATUS_OK));
            clear_buffer();
          end else begin
            last_chunk_end = 16'(stop);
          end
        end else if (last) begin
          // A trailing header of zeros is padding; anything else is corrupt.
          if (header_idx != 0 && !header_nonzero) begin
            len = last_chunk_end - block_begin;
            outs.insert(outs.size(), outcome(block_begin, len, len != 0, STATUS_OK));
          end else begin
            outs.insert(outs.size(), outcome('0, '0, 1'b0, STATUS_CORRUPT));
          end
          clear_buffer();
        end
      end

      if (outs.size() != 0) begin
        outs[outs.size() - 1].last_result = 1'b1;
      end
      foreach (outs[i]) begin
        expected_blocks.insert(expected_blocks.size(), outs[i]);
      end
    endfunction

    // Compares one result transaction with the oldest expected block.
    function void check_result(logic [OFS_W-1:0] start, logic [OFS_W-1:0] len,
                               logic has, logic [1:0] status, logic last_res);
      block_outcome_t want;
      if (expected_blocks.size() == 0) begin
        $error("result with nothing pending: block_start %0d block_length %0d status %0d",
               start, len, status);
        mismatches++;
        return;
      end
      want = expected_blocks.pop_front();
      if (start !== want.block_start) begin
        $error("block_start: expected %0d, actual %0d", want.block_start, start);
        mismatches++;
      end
      if (len !== want.block_length) begin
        $error("block_length: expected %0d, actual %0d", want.block_length, len);
        mismatches++;
      end
      if (has !== want.has_block) begin
        $error("has_block: expected %0d, actual %0d", want.has_block, has);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("buffer_status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (last_res !== want.last_result) begin
        $error("last_result: expected %0d, actual %0d", want.last_result, last_res);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ test/chunk_stream_block_splitter_tb.sv @@
// Testbench top for the chunk stream block splitter: directed and random buffers.
`timescale 1ns / 100ps
module chunk_stream_block_splitter_tb;
  import csbs_pkg::*;
  import csbs_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int BYTES_PER_PHASE = 340;
  localparam int SETTLE_CYCLES   = 10;
  localparam int DRAIN_CYCLES    = 20;

  logic clk;
  logic rst;

  csbs_byte_if   stream_if ();
  csbs_cfg_if    cfg_if ();
  csbs_result_if blocks_if ();

  block_scoreboard book = new();

  int send_idle_pct;
  int recv_stall_pct;
  int phase_bytes;
  int cycle_count;
  int send_idle_by_phase [4] = '{0, 88, 0, 23};
  int recv_stall_by_phase [4] = '{0, 0, 88, 23};
  logic [15:0] max_block_by_phase [4] = '{16'd1, 16'hFFFF, 16'd23, 16'd7};

  chunk_stream_block_splitter uut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .cfg    (cfg_if),
    .blocks (blocks_if)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver: check every result transaction, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && blocks_if.valid && blocks_if.ready) begin
      book.check_result(blocks_if.block_start, blocks_if.block_length, blocks_if.has_block,
                        blocks_if.buffer_status, blocks_if.last_result);
    end
    blocks_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offers one byte after a random gap and waits for its transaction.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.data_byte <= data;
    stream_if.last_byte <= last;
    stream_if.valid     <= 1'b1;
    do @(posedge clk); while (!stream_if.ready);
    book.note_byte(data, last);
    phase_bytes++;
  endtask

  task automatic send_buffer(ref logic [7:0] bytes_q[$]);
    foreach (bytes_q[i]) begin
      send_byte(bytes_q[i], i == bytes_q.size() - 1);
    end
  endtask

  // Stops the sender and waits until the splitter has nothing left to say.
  task automatic settle();
    stream_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The size limit only changes while the splitter is idle.
  task automatic write_max_block(input logic [15:0] value);
    settle();
    cfg_if.max_block_size <= value;
    cfg_if.valid          <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    book.set_max_block(value);
  endtask

  // Mostly short chunks, now and then one of any size.
  function automatic int unsigned pick_size();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(0, 255);
    end
    return $urandom_range(0, 10);
  endfunction

  // Appends a chunk header for size bytes and the first body bytes of its payload.
  function automatic void append_chunk(ref logic [7:0] bytes_q[$], input int unsigned size,
                                       input int unsigned body);
    bytes_q.insert(bytes_q.size(), 8'(size));
    repeat (CHUNK_HEADER - 1) begin
      bytes_q.insert(bytes_q.size(), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    end
    repeat (body) bytes_q.insert(bytes_q.size(), 8'($urandom));
  endfunction

  // One buffer: whole chunks, then a clean end, a padding header, a broken
  // header or a cut payload; a few buffers are pure noise.
  task automatic send_random_buffer();
    logic [7:0]  bytes_q[$];
    int unsigned kind;
    int unsigned size;
    kind = $urandom_range(0, 99);
    if (kind >= 93) begin
      repeat ($urandom_range(1, 12)) bytes_q.insert(bytes_q.size(), 8'($urandom));
    end else begin
      repeat ($urandom_range(0, 5)) begin
        size = pick_size();
        append_chunk(bytes_q, size, size);
      end
      if (kind < 60) begin
        size = pick_size();
        append_chunk(bytes_q, size, size);
      end else if (kind < 72) begin
        repeat ($urandom_range(1, CHUNK_HEADER - 1)) bytes_q.insert(bytes_q.size(), 8'h00);
      end else if (kind < 84) begin
        if ($urandom_range(0, 1) == 0) begin
          bytes_q.insert(bytes_q.size(), 8'($urandom_range(1, 255)));
        end else begin
          bytes_q.insert(bytes_q.size(), 8'h00);
          bytes_q.insert(bytes_q.size(), 8'($urandom_range(1, 255)));
        end
      end else begin
        size = pick_size();
        if (size == 0) begin
          size = 1;
        end
        append_chunk(bytes_q, size, $urandom_range(0, size - 1));
      end
    end
    send_buffer(bytes_q);
  endtask

  initial begin
    logic [7:0]  bytes_q[$];
    int          phase;

    stream_if.valid       <= 1'b0;
    stream_if.data_byte   <= '0;
    stream_if.last_byte   <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.max_block_size <= '0;
    rst                   <= 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    phase_bytes    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed buffers at the reset size limit.
    // A lone zero header byte: padding with an empty pending block.
    bytes_q = '{8'h00};
    send_buffer(bytes_q);
    // An empty chunk that ends the buffer.
    bytes_q = '{8'h00, 8'h00, 8'h00};
    send_buffer(bytes_q);
    // Partial header with a size byte, then one with a nonzero code byte.
    bytes_q = '{8'hFF};
    send_buffer(bytes_q);
    bytes_q = '{8'h00, 8'h80};
    send_buffer(bytes_q);
    // Payload cut short by the last byte.
    bytes_q = '{8'h02, 8'h01, 8'h02, 8'hAA};
    send_buffer(bytes_q);

    // Smallest limit: the first chunk is already too long, then padding ends it.
    write_max_block(16'd1);
    bytes_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h7F, 8'hFF, 8'h55, 8'h00, 8'h00};
    send_buffer(bytes_q);
    // A split and the end of the buffer on the same byte.
    bytes_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_buffer(bytes_q);

    // Random buffers under each idling pattern, with the limit changed now and then.
    for (phase = 0; phase < 4; phase++) begin
      write_max_block(max_block_by_phase[phase]);
      send_idle_pct  = send_idle_by_phase[phase];
      recv_stall_pct = recv_stall_by_phase[phase];
      phase_bytes    = 0;
      while (phase_bytes < BYTES_PER_PHASE) begin
        send_random_buffer();
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 7))
            0:       write_max_block(16'd1);
            1:       write_max_block(16'hFFFF);
            default: write_max_block(16'($urandom_range(2, 120)));
          endcase
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
